>>> rtl/core/bba_pkg.sv
// ============================================================================
// bba_pkg: shared types and constants of the bitmap block allocator
// Pool geometry, payload word types, controller states and the command
// bundle that the controller sends to the datapath.
// ============================================================================
package bba_pkg;

  // Pool geometry.
  localparam int BLOCK_COUNT = 64;
  localparam int BLOCK_BYTES = 64;

  localparam int ADDR_W   = 32;
  localparam int NUM_W    = 6;
  localparam int IDX_W    = $clog2(BLOCK_COUNT);
  localparam int BB_W     = $clog2(BLOCK_BYTES + 1);
  localparam int POOL_LEN = BLOCK_COUNT * BLOCK_BYTES;
  localparam int OFF_W    = $clog2(POOL_LEN);

  // Constant division of a pool offset by BLOCK_BYTES: multiply by a floor
  // reciprocal scaled by 2^OFF_W, then correct the quotient by at most one.
  localparam int RCP_W = OFF_W + 1;
  localparam longint RECIP = (longint'(1) << OFF_W) / BLOCK_BYTES;

  // First-free search: the map is summarized in groups of eight blocks.
  localparam int GRP   = 8;
  localparam int GRP_W = 3;
  localparam int NGRP  = (BLOCK_COUNT + GRP - 1) / GRP;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_POOL_BASE_ADDR = 2'd0;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] granted_address;
    logic [NUM_W-1:0]  block_number;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_MUL1,
    ST_FREE_MUL2,
    ST_FREE_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic alloc_pick;
    logic free_mul1;
    logic free_mul2;
    logic free_done;
  } bba_cmd_t;

endpackage

>>> rtl/core/bitmap_block_allocator_core.sv
// ============================================================================
// bitmap_block_allocator_core: first-fit allocator of fixed-size blocks
// One used/free bit per block of the pool. An allocate request takes the
// lowest-numbered free block and returns its address; a free request checks
// the address against the pool and clears the bit of the block holding it.
//
//   Channel   Ports                                Handshake
//   --------  -----------------------------------  ---------------------------
//   request   start, busy, in_word                 word taken when start & !busy
//   result    out_valid, out_word                  one-cycle strobe, no stall
//   config    psel, penable, pwrite, paddr,        two-phase write, pready
//             pwdata, prdata, pready               always high
//
// An allocate first registers the per-group free summary of the map, then
// picks the lowest free block and forms its address. A free steps through
// the offset and range check, the reciprocal multiply, the back-multiply
// and the quotient correction that clears the bit. The result word appears
// in the cycle in which busy has just dropped, and a new word may be started
// in that same cycle. The synchronous reset marks every block free and clears
// the pool base to zero; no clearing sweep is needed. The receiver cannot
// stall, so each result is valid for exactly one cycle.
// ============================================================================
module bitmap_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          start,
  output logic                          busy,
  input  bba_pkg::in_word_t             in_word,
  // Result channel.
  output logic                          out_valid,
  output bba_pkg::out_word_t            out_word,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::CFG_AW-1:0]    paddr,
  input  logic [bba_pkg::CFG_DW-1:0]    pwdata,
  output logic [bba_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import bba_pkg::*;

  bba_cmd_t          cmd;
  logic              cfg_we;
  logic [ADDR_W-1:0] pool_base;

  // The pool base is the only register; it is written in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_POOL_BASE_ADDR);
  assign prdata = (paddr == REG_POOL_BASE_ADDR) ? pool_base : '0;

  // The controller owns the handshake and sequences the datapath.
  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_word.func),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the map, the base and the result register.
  bba_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata),
    .pool_base (pool_base),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/bba_ctrl.sv
// ============================================================================
// bba_ctrl: request sequencer of the bitmap block allocator
// Accepts a request while idle and steps the datapath through the
// allocate or free sequence.
// ============================================================================
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              func,
  output logic              busy,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (func == FUNC_FREE) ? ST_FREE_MUL1 : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        cmd.alloc_pick = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_FREE_MUL1: begin
        cmd.free_mul1 = 1'b1;
        state_nxt     = ST_FREE_MUL2;
      end
      ST_FREE_MUL2: begin
        cmd.free_mul2 = 1'b1;
        state_nxt     = ST_FREE_DONE;
      end
      ST_FREE_DONE: begin
        cmd.free_done = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/bba_datapath.sv
// ============================================================================
// bba_datapath: block map, search and address arithmetic
// Holds the used/free map and the pool base, finds the first free block
// through a registered group summary, and turns a freed address into a
// block index by reciprocal multiplication.
// ============================================================================
module bba_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bba_pkg::bba_cmd_t             cmd,
  input  bba_pkg::in_word_t             in_word,
  input  logic                          cfg_we,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_wdata,
  output logic [bba_pkg::ADDR_W-1:0]    pool_base,
  output logic                          out_valid,
  output bba_pkg::out_word_t            out_word
);
  import bba_pkg::*;

  localparam int AOFF_W = IDX_W + BB_W;
  localparam int P1_W   = OFF_W + RCP_W;
  localparam logic [OFF_W-1:0]  BB_OFF    = OFF_W'(BLOCK_BYTES);
  localparam logic [RCP_W-1:0]  RECIP_C   = RCP_W'(RECIP);
  localparam logic [ADDR_W:0]   POOL_LEN_C = (ADDR_W + 1)'(POOL_LEN);

  function automatic logic [NUM_W-1:0] idx_to_num(input logic [IDX_W-1:0] idx);
    logic [IDX_W+NUM_W-1:0] ext;
    ext = {{NUM_W{1'b0}}, idx};
    return ext[NUM_W-1:0];
  endfunction

  logic [BLOCK_COUNT-1:0] used_map_r, used_map_nxt;
  logic [ADDR_W-1:0]      pool_base_r;
  logic [NGRP-1:0]        grp_free_r, grp_free_nxt;
  logic [GRP_W-1:0]       grp_pos_r   [NGRP];
  logic [GRP_W-1:0]       grp_pos_nxt [NGRP];
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic                   in_pool_r, in_pool_nxt;
  logic [IDX_W-1:0]       q_r, q_nxt;
  logic [OFF_W-1:0]       prod_r, prod_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  // Group summary: lowest free block inside each group of eight.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_nxt[g] = 1'b0;
      grp_pos_nxt[g]  = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if ((g * GRP + j) < BLOCK_COUNT) begin
          if (!used_map_r[g * GRP + j]) begin
            grp_free_nxt[g] = 1'b1;
            grp_pos_nxt[g]  = GRP_W'(j);
          end
        end
      end
    end
  end

  // Free path, first step: offset into the pool and the range check.
  always_comb begin
    logic [ADDR_W:0] diff;
    diff        = {1'b0, in_word.block_address} - {1'b0, pool_base_r};
    off_nxt     = diff[OFF_W-1:0];
    in_pool_nxt = (in_word.block_address != '0) && !diff[ADDR_W] &&
                  (diff < POOL_LEN_C);
  end

  // Estimated quotient and its product with the block size.
  always_comb begin
    logic [P1_W-1:0]   prod1;
    logic [AOFF_W-1:0] prod2;
    prod1    = P1_W'(off_r) * P1_W'(RECIP_C);
    q_nxt    = prod1[OFF_W +: IDX_W];
    prod2    = AOFF_W'(q_r) * AOFF_W'(BLOCK_BYTES);
    prod_nxt = prod2[OFF_W-1:0];
  end

  // Result stage for both requests, and the map update.
  always_comb begin
    logic              any;
    logic [IDX_W-1:0]  aidx;
    logic [AOFF_W-1:0] aoff;
    logic [OFF_W-1:0]  rem;
    logic [IDX_W-1:0]  fidx;
    any  = 1'b0;
    aidx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        any  = 1'b1;
        aidx = IDX_W'(g * GRP + int'(grp_pos_r[g]));
      end
    end
    aoff = AOFF_W'(aidx) * AOFF_W'(BLOCK_BYTES);
    rem  = off_r - prod_r;
    fidx = (rem >= BB_OFF) ? q_r + IDX_W'(1) : q_r;

    used_map_nxt  = used_map_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    if (cmd.alloc_pick) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      if (any) begin
        used_map_nxt[aidx]           = 1'b1;
        out_word_nxt.ok              = 1'b1;
        out_word_nxt.granted_address = pool_base_r + ADDR_W'(aoff);
        out_word_nxt.block_number    = idx_to_num(aidx);
      end
    end else if (cmd.free_done) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      if (in_pool_r) begin
        used_map_nxt[fidx]        = 1'b0;
        out_word_nxt.ok           = 1'b1;
        out_word_nxt.block_number = idx_to_num(fidx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_map_r  <= '0;
      pool_base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_map_r  <= used_map_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pool_base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (cmd.load) begin
      grp_free_r <= grp_free_nxt;
      grp_pos_r  <= grp_pos_nxt;
      off_r      <= off_nxt;
      in_pool_r  <= in_pool_nxt;
    end
    if (cmd.free_mul1) begin
      q_r <= q_nxt;
    end
    if (cmd.free_mul2) begin
      prod_r <= prod_nxt;
    end
  end

  assign pool_base = pool_base_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/bba_checker.sv
// ============================================================================
// bba_checker: port-level checks of the bitmap block allocator
// Watches the request and result ports and is bound to the top level.
// ============================================================================
module bba_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input bba_pkg::out_word_t out_word
);
  import bba_pkg::*;

  // Every accepted request makes the block go busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // A result is only shown once the sequence has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each request gives one result, so strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // The end of every sequence delivers its result word.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("sequence ended without a result");

  // A failed request returns zero address and zero block number.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.ok |->
      (out_word.granted_address == '0) && (out_word.block_number == '0))
    else $error("failed request returned nonzero fields");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

>>> tb/testbench.sv
// ============================================================================
// testbench: self-checking bench for the bitmap block allocator core
// Drives allocate and free request words through the start/busy command
// channel, keeps its own copy of the used/free map and the pool base, and
// compares every result strobe field by field against the predicted word.
// The pool base is reprogrammed over the APB-style port between phases,
// including both extremes and bases whose pool runs up to or past the top of
// the address space.
// ============================================================================
module testbench;
  import bba_pkg::*;

  // Clock, reset and every block input start at known values.
  logic clk;
  logic rst_n = 1'b0;

  logic      start   = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  bitmap_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the allocator state: one used bit per block plus the pool
  // base. Both match the reset state of the block.
  logic [BLOCK_COUNT-1:0] block_used = '0;
  logic [ADDR_W-1:0]      base_reg   = '0;

  in_word_t  request_fifo[$];    // words waiting to be started
  out_word_t expected_words[$];  // predicted results, oldest first
  int        error_count = 0;
  bit        gaps_on     = 1'b1; // sender idle bursts allowed
  int        gap_left    = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off long after the slowest correct run would finish.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Works out the result of one request word and updates the shadow map.
  // Allocate takes the lowest free block; the granted address is the 32-bit
  // sum, so it may wrap to zero. Free accepts only nonzero addresses in
  // [base, base + pool length), where the bound is taken without wrap, and
  // truncates the address to the block holding it.
  function automatic out_word_t allocator_result(input in_word_t req);
    out_word_t           res;
    int                  pick;
    logic [ADDR_W:0]     offset;
    res  = '0;
    pick = -1;
    if (req.func == FUNC_ALLOC) begin
      for (int i = 0; i < BLOCK_COUNT; i++)
        if (pick < 0 && !block_used[i]) pick = i;
      if (pick >= 0) begin
        block_used[pick]    = 1'b1;
        res.ok              = 1'b1;
        res.granted_address = base_reg + ADDR_W'(pick * BLOCK_BYTES);
        res.block_number    = NUM_W'(pick);
      end
    end else if (req.block_address != '0 && req.block_address >= base_reg) begin
      offset = {1'b0, req.block_address} - {1'b0, base_reg};
      if (offset < POOL_LEN) begin
        pick                = int'(offset) / BLOCK_BYTES;
        block_used[pick]    = 1'b0;
        res.ok              = 1'b1;
        res.block_number    = NUM_W'(pick);
      end
    end
    return res;
  endfunction

  // One random request. Most frees aim at a block of the current pool with
  // a random byte offset inside it; the rest are edge and noise addresses.
  function automatic in_word_t random_request(input int alloc_pct);
    in_word_t req;
    req.block_address = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      req.func = FUNC_ALLOC;
    end else begin
      req.func = FUNC_FREE;
      case ($urandom_range(0, 15))
        0:       req.block_address = '0;
        1:       req.block_address = base_reg - 1;
        2:       req.block_address = base_reg + POOL_LEN;
        3:       req.block_address = base_reg + POOL_LEN - 1;
        4:       req.block_address = '1;
        5:       ;  // fully random address
        default: req.block_address = base_reg
                   + ADDR_W'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES)
                   + ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
      endcase
    end
    return req;
  endfunction

  function automatic in_word_t request(input logic fn, input logic [ADDR_W-1:0] addr);
    in_word_t req;
    req.func          = fn;
    req.block_address = addr;
    return req;
  endfunction

  // Driver. A word is taken at an edge where start is high and busy is low;
  // the prediction is made at that same edge. start stays up while a word
  // waits for the block, and each signal gets one assignment per edge.
  always @(posedge clk) begin : driver
    logic taken;
    taken = start && !busy;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (taken) expected_words.push_back(allocator_result(in_word));
      if (start && !taken) begin
        // Hold the current word until the block takes it.
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_fifo.size() != 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        // Idle burst; start drops here and gap_left counts the rest of it.
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 11);
      end else if (request_fifo.size() != 0) begin
        start   <= 1'b1;
        in_word <= request_fifo.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Each strobe is one result word and must match the oldest
  // prediction in every field.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        log_error($sformatf("unexpected result ok=%0b addr=%h num=%0d",
                            out_word.ok, out_word.granted_address, out_word.block_number));
      end else begin
        want = expected_words.pop_front();
        if (out_word.ok !== want.ok || out_word.granted_address !== want.granted_address ||
            out_word.block_number !== want.block_number)
          log_error($sformatf("result ok=%0b addr=%h num=%0d, expected ok=%0b addr=%h num=%0d",
                              out_word.ok, out_word.granted_address, out_word.block_number,
                              want.ok, want.granted_address, want.block_number));
      end
    end
  end

  // Waits until every queued word has been taken and answered.
  task automatic drain();
    while (request_fifo.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle. A read is checked
  // against the shadow pool base at the edge that ends the access cycle.
  task automatic apb_transfer(input logic wr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_POOL_BASE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!wr && prdata !== base_reg)
      log_error($sformatf("pool base read %h, expected %h", prdata, base_reg));
    if (wr) base_reg = data;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lets the block go idle, then moves the pool to a new base.
  task automatic set_pool_base(input logic [ADDR_W-1:0] base);
    drain();
    repeat (6) @(posedge clk);
    apb_transfer(1'b1, base);
    apb_transfer(1'b0, '0);
  endtask

  task automatic queue_random(input int count, input int alloc_pct);
    repeat (count) request_fifo.push_back(random_request(alloc_pct));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Base zero: block 0 is granted at address zero with ok set, a free of
    // address zero is refused, an address inside a block frees that block,
    // a second free of the same block still succeeds, and the first address
    // past the pool end is refused.
    set_pool_base('0);
    repeat (4) request_fifo.push_back(request(FUNC_ALLOC, $urandom));
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_0000));
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_0051));
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_0040));
    request_fifo.push_back(request(FUNC_ALLOC, '1));
    request_fifo.push_back(request(FUNC_FREE, POOL_LEN - 1));
    request_fifo.push_back(request(FUNC_FREE, POOL_LEN));
    request_fifo.push_back(request(FUNC_FREE, 32'hFFFF_FFFF));
    request_fifo.push_back(request(FUNC_FREE, 32'h8000_0000));
    queue_random(110, 60);

    // Nonzero base: an address just below the pool is refused. The heavy
    // allocate mix then runs the pool full and keeps hitting that case.
    set_pool_base(32'h0000_1000);
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_0FFF));
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_1000));
    request_fifo.push_back(request(FUNC_FREE, 32'h0000_1000 + POOL_LEN));
    request_fifo.push_back(request(FUNC_ALLOC, '0));
    queue_random(150, 85);

    // Top of the address space: only one byte of the pool is addressable.
    set_pool_base('1);
    queue_random(80, 50);

    // Granted addresses wrap past zero, and those blocks cannot be freed.
    set_pool_base(32'hFFFF_FFC0);
    queue_random(100, 50);

    set_pool_base($urandom);
    queue_random(120, 40);

    // The pool ends exactly at the top of the address space. The sender
    // runs without idle bursts here.
    set_pool_base(32'hFFFF_F000);
    gaps_on = 1'b0;
    queue_random(120, 55);

    drain();
    repeat (8) @(posedge clk);
    error_count += expected_words.size();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> bitmap_block_allocator_core.f
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_datapath.sv
rtl/core/bitmap_block_allocator_core.sv
rtl/core/bba_checker.sv
tb/testbench.sv
